// ===== sv/ffcca_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the first-fit contiguous channel allocator.
// No dependencies.
package ffcca_pkg;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_MARK,
        ST_FIN
    } t_state;

    localparam int CFG_W    = 9;
    localparam int BW_W     = 12;
    localparam int CNT_W    = 9;
    localparam int FIRST_W  = 8;

    localparam logic [12:0] ROUND_UP_ADD = 13'd9;
    localparam logic [15:0] DIV10_RECIP  = 16'd52429;
    localparam int          DIV10_SHIFT  = 19;

    localparam logic [CFG_W-1:0] NUM_CHANNELS_RST = 9'd256;

    // ceil(bw / 10) through a reciprocal multiply, exact for every 12-bit input
    function automatic logic [CNT_W-1:0] ceil_div10(input logic [BW_W-1:0] bw);
        logic [12:0] x;
        logic [28:0] p;
        x = {1'b0, bw} + ROUND_UP_ADD;
        p = 29'(x) * 29'(DIV10_RECIP);
        return CNT_W'(p >> DIV10_SHIFT);
    endfunction

endpackage

// ===== sv/ffcca_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ffcca_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/first_fit_contiguous_channel_allocator.sv =====
`timescale 1ns / 1ps
// One request at a time, busy high throughout, from the accepting edge to the o_valid strobe.
// The scan reads one occupancy bit per cycle from the map RAM; marking writes one per cycle.
// Reset clears control state and then sweeps the map RAM to free, one channel per cycle
// over all min(MAX_CHANNELS, 512) entries, with busy high. Results cannot be stalled.
// Depends on ffcca_pkg and ffcca_ram.
module first_fit_contiguous_channel_allocator #(
    parameter int MAX_CHANNELS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [11:0] i_bandwidth,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,
    output logic        o_valid,
    output logic        o_granted,
    output logic [7:0]  o_first_channel,
    output logic [8:0]  o_channels_needed,
    output logic [8:0]  o_used_total,
    output logic [8:0]  o_free_left
);

    localparam int DEPTH = (MAX_CHANNELS < 512) ? MAX_CHANNELS : 512;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    ffcca_pkg::t_state r_state, n_state;

    logic [8:0] r_cfg;
    logic [8:0] r_idx, n_idx;
    logic [8:0] r_run, n_run;
    logic [8:0] r_chk, n_chk;
    logic       r_dv, n_dv;
    logic [8:0] r_needed, n_needed;
    logic [8:0] r_first, n_first;
    logic       r_grant, n_grant;
    logic [8:0] r_used, n_used;

    logic       r_o_valid, n_o_valid;
    logic       r_o_granted, n_o_granted;
    logic [7:0] r_o_first, n_o_first;
    logic [8:0] r_o_needed, n_o_needed;
    logic [8:0] r_o_used, n_o_used;
    logic [8:0] r_o_free, n_o_free;

    logic [8:0] eff;
    logic [8:0] run_inc;
    logic       hit;
    logic       ram_we;
    logic       ram_wdata;
    logic       ram_rdata;

    assign eff = ({1'b0, r_cfg} > 10'(DEPTH)) ? 9'(DEPTH) : r_cfg;
    assign run_inc = r_run + 9'd1;
    assign hit = r_dv && !ram_rdata && (run_inc == r_needed);

    ffcca_ram #(
        .WIDTH(1),
        .DEPTH(DEPTH)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(AW'(r_idx)),
        .i_wdata(ram_wdata),
        .i_raddr(AW'(r_idx)),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= ffcca_pkg::NUM_CHANNELS_RST;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ffcca_pkg::ST_CLR;
            r_idx     <= '0;
            r_dv      <= 1'b0;
            r_used    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_dv      <= n_dv;
            r_used    <= n_used;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_run       <= n_run;
        r_chk       <= n_chk;
        r_needed    <= n_needed;
        r_first     <= n_first;
        r_grant     <= n_grant;
        r_o_granted <= n_o_granted;
        r_o_first   <= n_o_first;
        r_o_needed  <= n_o_needed;
        r_o_used    <= n_o_used;
        r_o_free    <= n_o_free;
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_run       = r_run;
        n_chk       = r_chk;
        n_dv        = 1'b0;
        n_needed    = r_needed;
        n_first     = r_first;
        n_grant     = r_grant;
        n_used      = r_used;
        n_o_valid   = 1'b0;
        n_o_granted = r_o_granted;
        n_o_first   = r_o_first;
        n_o_needed  = r_o_needed;
        n_o_used    = r_o_used;
        n_o_free    = r_o_free;
        ram_we      = 1'b0;
        ram_wdata   = 1'b0;

        case (r_state)
            ffcca_pkg::ST_CLR: begin
                ram_we = 1'b1;
                n_idx  = r_idx + 9'd1;
                if (r_idx == 9'(DEPTH - 1)) begin
                    n_idx   = '0;
                    n_state = ffcca_pkg::ST_IDLE;
                end
            end
            ffcca_pkg::ST_IDLE: begin
                if (start) begin
                    n_needed = ffcca_pkg::ceil_div10(i_bandwidth);
                    n_state  = ffcca_pkg::ST_PREP;
                end
            end
            ffcca_pkg::ST_PREP: begin
                n_idx   = '0;
                n_run   = '0;
                n_first = '0;
                if (r_needed == '0) begin
                    n_grant = 1'b1;
                    n_state = ffcca_pkg::ST_FIN;
                end else if (r_needed > eff) begin
                    n_grant = 1'b0;
                    n_state = ffcca_pkg::ST_FIN;
                end else begin
                    n_state = ffcca_pkg::ST_SCAN;
                end
            end
            ffcca_pkg::ST_SCAN: begin
                n_chk = r_idx;
                if (r_idx < eff) begin
                    n_dv  = 1'b1;
                    n_idx = r_idx + 9'd1;
                end
                if (r_dv) begin
                    n_run = ram_rdata ? 9'd0 : run_inc;
                end
                if (hit) begin
                    n_first = r_chk + 9'd1 - r_needed;
                    n_idx   = r_chk + 9'd1 - r_needed;
                    n_run   = r_needed;
                    n_dv    = 1'b0;
                    n_state = ffcca_pkg::ST_MARK;
                end else if (!r_dv && (r_idx >= eff)) begin
                    n_grant = 1'b0;
                    n_first = '0;
                    n_state = ffcca_pkg::ST_FIN;
                end
            end
            ffcca_pkg::ST_MARK: begin
                ram_we    = 1'b1;
                ram_wdata = 1'b1;
                n_idx     = r_idx + 9'd1;
                n_run     = r_run - 9'd1;
                if (r_run == 9'd1) begin
                    n_used  = r_used + r_needed;
                    n_grant = 1'b1;
                    n_state = ffcca_pkg::ST_FIN;
                end
            end
            ffcca_pkg::ST_FIN: begin
                n_o_valid   = 1'b1;
                n_o_granted = r_grant;
                n_o_first   = r_first[7:0];
                n_o_needed  = r_needed;
                n_o_used    = r_used;
                n_o_free    = (eff > r_used) ? (eff - r_used) : 9'd0;
                n_state     = ffcca_pkg::ST_IDLE;
            end
            default: begin
                n_state = ffcca_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy              = (r_state != ffcca_pkg::ST_IDLE);
    assign o_valid           = r_o_valid;
    assign o_granted         = r_o_granted;
    assign o_first_channel   = r_o_first;
    assign o_channels_needed = r_o_needed;
    assign o_used_total      = r_o_used;
    assign o_free_left       = r_o_free;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for first_fit_contiguous_channel_allocator: directed and random
// bandwidth requests across several channel-count settings, checked against an in-bench model.
// Depends on ffcca_pkg and the allocator RTL.
module tb;

    localparam int  BW_W      = ffcca_pkg::BW_W;
    localparam int  CFG_W     = ffcca_pkg::CFG_W;
    localparam int  CNT_W     = ffcca_pkg::CNT_W;
    localparam int  FIRST_W   = ffcca_pkg::FIRST_W;
    localparam int  NCHAN     = 256;
    localparam int  PER_CHUNK = 140;
    localparam int  N_CHUNKS  = 12;
    localparam int  DRAIN_CYC = 800;
    localparam longint LIMIT  = 5_000_000;

    typedef struct packed {
        logic               granted;
        logic [FIRST_W-1:0] first_channel;
        logic [CNT_W-1:0]   channels_needed;
        logic [CNT_W-1:0]   used_total;
        logic [CNT_W-1:0]   free_left;
    } t_grant;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [BW_W-1:0]    i_bandwidth;
    logic               i_cfg_we;
    logic [CFG_W-1:0]   i_cfg_wdata;
    logic               o_valid;
    logic               o_granted;
    logic [FIRST_W-1:0] o_first_channel;
    logic [CNT_W-1:0]   o_channels_needed;
    logic [CNT_W-1:0]   o_used_total;
    logic [CNT_W-1:0]   o_free_left;

    logic [BW_W-1:0]    req_q[$];
    t_grant             grant_exp_q[$];
    bit                 chan_map[NCHAN];
    int                 used_chans;
    int                 num_chans;
    int                 idle_pct;
    int                 err_cnt;
    longint             cyc;
    logic               item_taken;

    first_fit_contiguous_channel_allocator u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_bandwidth       (i_bandwidth),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .o_valid           (o_valid),
        .o_granted         (o_granted),
        .o_first_channel   (o_first_channel),
        .o_channels_needed (o_channels_needed),
        .o_used_total      (o_used_total),
        .o_free_left       (o_free_left)
    );

    always #2 i_clk = ~i_clk;

    // First-fit search over the occupancy map; updates the map and the used count.
    function automatic t_grant predict_grant(input logic [BW_W-1:0] bw);
        int     needed;
        int     n;
        int     run;
        int     first;
        bit     ok;
        t_grant r;
        needed = (int'(bw) + 9) / 10;
        n      = (num_chans > NCHAN) ? NCHAN : num_chans;
        run    = 0;
        first  = 0;
        ok     = (needed == 0);
        if (needed != 0 && needed <= n) begin
            for (int i = 0; i < n && !ok; i++) begin
                if (chan_map[i]) begin
                    run = 0;
                end else begin
                    run++;
                    if (run == needed) begin
                        first = i + 1 - needed;
                        ok    = 1'b1;
                    end
                end
            end
            if (ok) begin
                for (int j = first; j < first + needed; j++) chan_map[j] = 1'b1;
                used_chans += needed;
            end
        end
        r.granted         = ok;
        r.first_channel   = ok ? FIRST_W'(first) : '0;
        r.channels_needed = CNT_W'(needed);
        r.used_total      = CNT_W'(used_chans);
        r.free_left       = CNT_W'((n > used_chans) ? n - used_chans : 0);
        return r;
    endfunction

    function automatic logic [BW_W-1:0] pick_bandwidth();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70) return BW_W'($urandom_range(0, 30));
        if (sel < 88) return BW_W'($urandom_range(31, 400));
        return BW_W'($urandom_range(0, 4095));
    endfunction

    // Driver: hold start until accepted, then advance or idle.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start       <= 1'b0;
            i_bandwidth <= '0;
        end else if (!start || item_taken) begin
            if (req_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                i_bandwidth <= req_q.pop_front();
                start       <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: track config, check results, predict on accept.
    always @(posedge i_clk) begin
        t_grant e;
        cyc <= cyc + 1;
        if (cyc > LIMIT) begin
            $display("Verification failed");
            $finish;
        end
        if (!i_rst_n) begin
            item_taken <= 1'b0;
            used_chans = 0;
            num_chans  = int'(ffcca_pkg::NUM_CHANNELS_RST);
            foreach (chan_map[i]) chan_map[i] = 1'b0;
        end else begin
            item_taken <= start && !busy;
            if (i_cfg_we) num_chans = int'(i_cfg_wdata);
            if (o_valid) begin
                if (grant_exp_q.size() == 0) begin
                    $error("result with no pending request");
                    err_cnt++;
                end else begin
                    e = grant_exp_q.pop_front();
                    if (o_granted !== e.granted) begin
                        $error("granted: expected %0d, got %0d", e.granted, o_granted);
                        err_cnt++;
                    end
                    if (o_first_channel !== e.first_channel) begin
                        $error("first_channel: expected %0d, got %0d",
                               e.first_channel, o_first_channel);
                        err_cnt++;
                    end
                    if (o_channels_needed !== e.channels_needed) begin
                        $error("channels_needed: expected %0d, got %0d",
                               e.channels_needed, o_channels_needed);
                        err_cnt++;
                    end
                    if (o_used_total !== e.used_total) begin
                        $error("used_total: expected %0d, got %0d", e.used_total, o_used_total);
                        err_cnt++;
                    end
                    if (o_free_left !== e.free_left) begin
                        $error("free_left: expected %0d, got %0d", e.free_left, o_free_left);
                        err_cnt++;
                    end
                end
            end
            if (start && !busy) grant_exp_q = {grant_exp_q, predict_grant(i_bandwidth)};
        end
    end

    task automatic wait_drained();
        do @(negedge i_clk);
        while (req_q.size() != 0 || start || grant_exp_q.size() != 0 || busy);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_channels(input int value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CFG_W'(value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int cfg_edge[6];
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_bandwidth = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        idle_pct    = 36;
        err_cnt     = 0;
        cyc         = 0;
        cfg_edge    = '{256, 0, 511, 1, 255, 257};
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // default count: zero request, oversize, rounding edges
        req_q = '{12'd0, 12'd4095, 12'd2561, 12'd1, 12'd10, 12'd11, 12'd9, 12'd20};
        wait_drained();
        // zero channels: only the zero request is granted
        write_channels(0);
        req_q = '{12'd0, 12'd1, 12'd4095};
        wait_drained();
        // count above the maximum saturates
        write_channels(511);
        req_q = '{12'd19, 12'd21, 12'd2048};
        wait_drained();
        // count lowered below channels in use
        write_channels(3);
        req_q = '{12'd0, 12'd5, 12'd10};
        wait_drained();

        for (int k = 0; k < N_CHUNKS; k++) begin
            idle_pct = (k < 4) ? 36 : (k < 8) ? 86 : 0;
            write_channels((k < 6) ? cfg_edge[k] : int'($urandom_range(0, 511)));
            for (int m = 0; m < PER_CHUNK; m++) req_q = {req_q, pick_bandwidth()};
            wait_drained();
        end

        repeat (DRAIN_CYC) @(negedge i_clk);
        if (err_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
